// File: design/odometer_velocity_estimator_unit_assert.svh
// Assertion macros shared by the checker of the odometer velocity estimator.
// Depends on nothing; included by the checker file.
`ifndef ODOMETER_VELOCITY_ESTIMATOR_UNIT_ASSERT_SVH
`define ODOMETER_VELOCITY_ESTIMATOR_UNIT_ASSERT_SVH

// The consequent must hold in the clock after the antecedent.
`define OVE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same clock as the antecedent.
`define OVE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/ove_pkg.sv
// Shared widths, register indices and constants of the odometer velocity estimator.
// Depends on nothing; used by the top level and its checker.
package ove_pkg;

	localparam int COUNT_BITS = 32;
	localparam int TIME_BITS = 32;

	localparam int FIELD_BITS = 32;
	localparam int IN_DATA_BITS = 3 * FIELD_BITS;
	localparam int SPEED_BITS = 32;

	localparam int TICK_LEN_BITS = 20;
	localparam int TIMEOUT_BITS = 24;
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS = 24;

	localparam logic [CFG_INDEX_BITS-1:0] REG_TICK_LENGTH = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STALE_TIMEOUT = 8'd1;

	localparam logic [TICK_LEN_BITS-1:0] TICK_LEN_RESET = 20'd1000;
	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 24'd100000;

	// Micrometres per tick times this gives nanometre-per-tick, i.e. mm/s over us.
	localparam logic [31:0] UM_TO_MM_SCALE = 32'd1000;
	localparam int SCALE_BITS = 30;

	localparam int PRODUCT_BITS = 64;
	localparam int DIVIDEND_BITS = 62;
	localparam int QUO_BITS = 31;
	localparam int ITER_BITS = $clog2(QUO_BITS);

	localparam logic [SPEED_BITS-1:0] SPEED_MAX = {1'b0, {(SPEED_BITS-1){1'b1}}};
	localparam logic [SPEED_BITS-1:0] SPEED_MIN = {1'b1, {(SPEED_BITS-1){1'b0}}};

endpackage

// File: design/odometer_velocity_estimator_unit.sv
// Odometer velocity estimator: microcoded sequencer, shared multiplier and
// a restoring divider. Depends on ove_pkg.
//
// Each input transaction on s_axis carries one sensor report in s_axis_tdata:
// tick_count in bits 31:0, tick_time_us in bits 63:32 and now_us in bits 95:64.
// Each report yields exactly one output transaction on m_axis: the speed in mm/s
// in m_axis_tdata and the fresh-tick flag in m_axis_tuser.
// The configuration channel writes tick_length_um (index 0) or stale_timeout_us
// (index 1) and is always ready; the user must write it only while the block is
// idle, which the block itself does not enforce. One report is processed at a time.
// A report that needs a division (a new tick or a limited speed) passes through
// the 31 iterations of the one-bit-per-cycle divider. Other reports skip the
// divider, the first report after reset being the shortest. The
// output register lets the sequencer return to its wait step while a result is
// pending, so the next report is taken in the cycle after the result is
// registered; if the receiver stalls, the sequencer waits in its final step
// until the output register frees. Reset clears the state, loads the register
// defaults and leaves both channels empty; the first report after reset gives zero.
module odometer_velocity_estimator_unit
	import ove_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,   // tick_count, tick_time_us, now_us
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [SPEED_BITS-1:0]     m_axis_tdata,   // speed_mm_s
	output logic                      m_axis_tuser,   // fresh_tick
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_SCALE    = 4'd1;
	localparam logic [3:0] OP_MULMAG   = 4'd2;
	localparam logic [3:0] OP_LOADA    = 4'd3;
	localparam logic [3:0] OP_MULDELTA = 4'd4;
	localparam logic [3:0] OP_DIVSET   = 4'd5;
	localparam logic [3:0] OP_DIVSTEP  = 4'd6;
	localparam logic [3:0] OP_DIVEND   = 4'd7;
	localparam logic [3:0] OP_HELD     = 4'd8;
	localparam logic [3:0] OP_ZERO     = 4'd9;
	localparam logic [3:0] OP_VER      = 4'd10;
	localparam logic [3:0] OP_EMIT     = 4'd11;

	localparam logic [3:0] C_NEXT       = 4'd0;
	localparam logic [3:0] C_ALWAYS     = 4'd1;
	localparam logic [3:0] C_NO_IN      = 4'd2;
	localparam logic [3:0] C_NOT_PRIMED = 4'd3;
	localparam logic [3:0] C_TICK_MOVED = 4'd4;
	localparam logic [3:0] C_STALE      = 4'd5;
	localparam logic [3:0] C_SINCE_ZERO = 4'd6;
	localparam logic [3:0] C_A_GT_MUL   = 4'd7;
	localparam logic [3:0] C_ITER_MORE  = 4'd8;
	localparam logic [3:0] C_OUT_BUSY   = 4'd9;

	localparam logic [3:0] S_WAIT    = 4'd0;
	localparam logic [3:0] S_SCALE   = 4'd1;
	localparam logic [3:0] S_MOVED   = 4'd2;
	localparam logic [3:0] S_STALE   = 4'd3;
	localparam logic [3:0] S_SZERO   = 4'd4;
	localparam logic [3:0] S_MULMAG  = 4'd5;
	localparam logic [3:0] S_CMP     = 4'd6;
	localparam logic [3:0] S_LOADA   = 4'd7;
	localparam logic [3:0] S_NEW     = 4'd8;
	localparam logic [3:0] S_DIVSET  = 4'd9;
	localparam logic [3:0] S_DIVSTEP = 4'd10;
	localparam logic [3:0] S_DIVEND  = 4'd11;
	localparam logic [3:0] S_FIRST   = 4'd12;
	localparam logic [3:0] S_ZERO    = 4'd13;
	localparam logic [3:0] S_VER     = 4'd14;
	localparam logic [3:0] S_EMIT    = 4'd15;

	typedef struct packed {
		logic [3:0] op;
		logic [3:0] cond;
		logic [3:0] target;
	} ucode_t;

	// Control store. A step jumps to its target when its condition holds and
	// otherwise falls through; the last step wraps round to the wait step.
	function automatic ucode_t ucode_rom(input logic [3:0] step);
		ucode_t w;
		case (step)
			S_WAIT:    w = '{OP_NONE,     C_NO_IN,      S_WAIT};
			S_SCALE:   w = '{OP_SCALE,    C_NOT_PRIMED, S_FIRST};
			S_MOVED:   w = '{OP_NONE,     C_TICK_MOVED, S_NEW};
			S_STALE:   w = '{OP_NONE,     C_STALE,      S_ZERO};
			S_SZERO:   w = '{OP_NONE,     C_SINCE_ZERO, S_VER};
			S_MULMAG:  w = '{OP_MULMAG,   C_NEXT,       S_WAIT};
			S_CMP:     w = '{OP_NONE,     C_A_GT_MUL,   S_VER};
			S_LOADA:   w = '{OP_LOADA,    C_ALWAYS,     S_DIVSET};
			S_NEW:     w = '{OP_MULDELTA, C_NEXT,       S_WAIT};
			S_DIVSET:  w = '{OP_DIVSET,   C_NEXT,       S_WAIT};
			S_DIVSTEP: w = '{OP_DIVSTEP,  C_ITER_MORE,  S_DIVSTEP};
			S_DIVEND:  w = '{OP_DIVEND,   C_ALWAYS,     S_EMIT};
			S_FIRST:   w = '{OP_HELD,     C_ALWAYS,     S_EMIT};
			S_ZERO:    w = '{OP_ZERO,     C_ALWAYS,     S_EMIT};
			S_VER:     w = '{OP_VER,      C_NEXT,       S_WAIT};
			S_EMIT:    w = '{OP_EMIT,     C_OUT_BUSY,   S_EMIT};
			default:   w = '{OP_NONE,     C_ALWAYS,     S_WAIT};
		endcase
		return w;
	endfunction

	logic [3:0]                pc_q;
	ucode_t                    uw;
	logic                      jump;

	logic [TICK_LEN_BITS-1:0]  tick_len_q;
	logic [TIMEOUT_BITS-1:0]   stale_q;
	logic [COUNT_BITS-1:0]     prior_count_q;
	logic [TIME_BITS-1:0]      prior_tick_q;
	logic                      primed_q;
	logic [SPEED_BITS-1:0]     verified_q;
	logic [SPEED_BITS-1:0]     held_q;
	logic                      out_valid_q;

	logic [COUNT_BITS-1:0]     cnt_q;
	logic [TIME_BITS-1:0]      tt_q;
	logic [TIME_BITS-1:0]      now_q;
	logic                      fresh_q;
	logic [SCALE_BITS-1:0]     a_q;
	logic [PRODUCT_BITS-1:0]   mul_q;
	logic [31:0]               divisor_q;
	logic [31:0]               rem_q;
	logic [QUO_BITS-1:0]       quo_q;
	logic [ITER_BITS-1:0]      iter_q;
	logic                      neg_q;
	logic                      sat_q;
	logic [SPEED_BITS-1:0]     res_q;
	logic [SPEED_BITS-1:0]     out_speed_q;
	logic                      out_fresh_q;

	logic                      in_take;
	logic                      out_busy;
	logic                      emit;
	logic [TIME_BITS-1:0]      since;
	logic [TIME_BITS-1:0]      dt;
	logic [COUNT_BITS-1:0]     diff;
	logic [COUNT_BITS-1:0]     mag_delta;
	logic [SPEED_BITS-1:0]     mag_ver;
	logic [31:0]               mul_x;
	logic [31:0]               mul_y;
	logic [PRODUCT_BITS-1:0]   product;
	logic [32:0]               div_try;
	logic [32:0]               div_diff;
	logic                      div_ge;
	logic [SPEED_BITS-1:0]     quo_ext;
	logic [SPEED_BITS-1:0]     div_res;

	assign uw = ucode_rom(pc_q);

	assign s_axis_tready = (pc_q == S_WAIT);
	assign in_take = s_axis_tvalid && s_axis_tready;
	assign out_busy = out_valid_q && !m_axis_tready;
	assign emit = (uw.op == OP_EMIT) && !out_busy;
	assign cfg_ready = 1'b1;

	assign since = now_q - tt_q;
	assign dt = tt_q - prior_tick_q;
	assign diff = cnt_q - prior_count_q;
	assign mag_delta = diff[COUNT_BITS-1] ? (~diff + 1'b1) : diff;
	assign mag_ver = verified_q[SPEED_BITS-1] ? (~verified_q + 1'b1) : verified_q;

	assign mul_x = (uw.op == OP_MULDELTA) ? 32'(mag_delta) : 32'(mag_ver);
	assign mul_y = (uw.op == OP_MULDELTA) ? 32'(a_q) : 32'(since);
	assign product = 64'(mul_x) * 64'(mul_y);

	assign div_try = {rem_q, quo_q[QUO_BITS-1]};
	assign div_ge = div_try >= {1'b0, divisor_q};
	assign div_diff = div_try - {1'b0, divisor_q};

	assign quo_ext = SPEED_BITS'(quo_q);
	always_comb begin
		if (sat_q) begin
			div_res = neg_q ? SPEED_MIN : SPEED_MAX;
		end else begin
			div_res = neg_q ? (~quo_ext + 1'b1) : quo_ext;
		end
	end

	always_comb begin
		case (uw.cond)
			C_NEXT:       jump = 1'b0;
			C_ALWAYS:     jump = 1'b1;
			C_NO_IN:      jump = !s_axis_tvalid;
			C_NOT_PRIMED: jump = !primed_q;
			C_TICK_MOVED: jump = (tt_q != prior_tick_q);
			C_STALE:      jump = (32'(since) > 32'(stale_q));
			C_SINCE_ZERO: jump = (since == '0);
			C_A_GT_MUL:   jump = (PRODUCT_BITS'(a_q) > mul_q);
			C_ITER_MORE:  jump = (iter_q != ITER_BITS'(QUO_BITS - 1));
			C_OUT_BUSY:   jump = out_busy;
			default:      jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_WAIT;
			tick_len_q <= TICK_LEN_RESET;
			stale_q <= TIMEOUT_RESET;
			prior_count_q <= '0;
			prior_tick_q <= '0;
			primed_q <= 1'b0;
			verified_q <= '0;
			held_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= jump ? uw.target : pc_q + 4'd1;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TICK_LENGTH) begin
					tick_len_q <= cfg_data[TICK_LEN_BITS-1:0];
				end else if (cfg_index == REG_STALE_TIMEOUT) begin
					stale_q <= cfg_data[TIMEOUT_BITS-1:0];
				end
			end
			if (emit) begin
				prior_count_q <= cnt_q;
				prior_tick_q <= tt_q;
				primed_q <= 1'b1;
				held_q <= res_q;
				if (fresh_q) begin
					verified_q <= res_q;
				end
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cnt_q <= s_axis_tdata[COUNT_BITS-1:0];
			tt_q <= s_axis_tdata[FIELD_BITS +: TIME_BITS];
			now_q <= s_axis_tdata[2*FIELD_BITS +: TIME_BITS];
			fresh_q <= 1'b0;
		end
		if (emit) begin
			out_speed_q <= res_q;
			out_fresh_q <= fresh_q;
		end
		case (uw.op)
			OP_SCALE: begin
				a_q <= SCALE_BITS'(32'(tick_len_q) * UM_TO_MM_SCALE);
			end
			OP_MULMAG: begin
				mul_q <= product;
			end
			OP_LOADA: begin
				mul_q <= PRODUCT_BITS'(a_q);
				divisor_q <= 32'(since);
				neg_q <= verified_q[SPEED_BITS-1] || (verified_q == '0);
			end
			OP_MULDELTA: begin
				mul_q <= product;
				divisor_q <= 32'(dt);
				neg_q <= diff[COUNT_BITS-1];
				fresh_q <= 1'b1;
			end
			OP_DIVSET: begin
				rem_q <= 32'(mul_q[DIVIDEND_BITS-1:QUO_BITS]);
				quo_q <= mul_q[QUO_BITS-1:0];
				sat_q <= (32'(mul_q[DIVIDEND_BITS-1:QUO_BITS]) >= divisor_q);
				iter_q <= '0;
			end
			OP_DIVSTEP: begin
				rem_q <= div_ge ? div_diff[31:0] : div_try[31:0];
				quo_q <= {quo_q[QUO_BITS-2:0], div_ge};
				iter_q <= iter_q + 1'b1;
			end
			OP_DIVEND: begin
				res_q <= div_res;
			end
			OP_HELD: begin
				res_q <= held_q;
			end
			OP_ZERO: begin
				res_q <= '0;
			end
			OP_VER: begin
				res_q <= verified_q;
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_speed_q;
	assign m_axis_tuser = out_fresh_q;

endmodule

// File: design/ove_checker.sv
// Port-level checker of the odometer velocity estimator, bound to the top level.
// Depends on ove_pkg and odometer_velocity_estimator_unit_assert.svh.
`include "odometer_velocity_estimator_unit_assert.svh"

module ove_checker
	import ove_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [SPEED_BITS-1:0] m_axis_tdata,   // speed_mm_s
	input logic                  m_axis_tuser    // fresh_tick
);

	// A stalled result transaction keeps its contents.
	`OVE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// Only one report is in work at a time.
	`OVE_ASSERT_NEXT(a_one_in_work, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "report accepted while another is in work")

	// A result never appears in the cycle right after a report is taken.
	`OVE_ASSERT_NEXT(a_no_instant_result, clk, arst_n, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid, "result appeared too early")

endmodule

bind odometer_velocity_estimator_unit ove_checker u_ove_checker (.*);
